FILE: design/usd_pkg.sv
// usd_pkg: shared types and constants for the UTF-8 stream decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package usd_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_VALID      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;

    localparam logic [CP_W-1:0] MIN_LEN2 = 21'h00007F;
    localparam logic [CP_W-1:0] MIN_LEN3 = 21'h0007FF;
    localparam logic [CP_W-1:0] MIN_LEN4 = 21'h00FFFF;
    localparam logic [CP_W-1:0] MAX_CODE = 21'h10FFFF;

    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    typedef enum logic [2:0] {
        K_ASCII,
        K_CONT,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_BAD,
        K_FLUSH
    } usd_kind_t;

    typedef struct packed {
        usd_kind_t  kind;
        logic [6:0] bits;   // payload bits of the byte, right aligned
    } usd_item_t;

endpackage

`default_nettype wire

FILE: design/utf8_stream_decoder.sv
// utf8_stream_decoder: top level, byte stream in, code points out.
// Instantiates usd_front, usd_queue and usd_back; depends on usd_pkg.
//
//  channel | dir | tdata                          | side band
//  s_      | in  | [7:0] data byte                | tlast = flush
//  m_      | out | [20:0] code point, [23:21] len | tuser[1:0] = status
//
// One byte per clock while m_tready is high; each byte is queued before decode.
// Rate is set by the combinational decode step in usd_back.
// The two-entry queue holds bytes over an output stall until s_tready drops.
// aresetn is synchronous, active low, and returns the decoder to idle.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] seq_length
    output logic [1:0]       m_tuser    // [1:0] status
);
    import usd_pkg::*;

    usd_item_t  push_item;
    usd_item_t  pop_item;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    logic [1:0] q_count;

    usd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    usd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item),
        .count     (q_count)
    );

    usd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count != 2'd3)
        else $error("queue count out of range");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_VALID) |-> (m_tdata == 24'd0))
        else $error("error result carries data");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_VALID || m_tuser == ST_INVALID
                      || m_tuser == ST_INCOMPLETE))
        else $error("undefined status");

    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_VALID && m_tdata[23:21] == 3'd0)
            |-> (m_tdata[20:0] == 21'd0))
        else $error("zero length with non-zero code point");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && q_count == 2'd0))
        else $error("not idle after reset");

endmodule

`default_nettype wire

FILE: design/usd_front.sv
// usd_front: accepts raw bytes and classifies them into queue items.
// Depends on usd_pkg.
`default_nettype none

module usd_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          q_full,
    output logic               q_push,
    output usd_pkg::usd_item_t q_item
);
    import usd_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.bits = s_tdata[6:0];
        if (s_tlast) begin
            q_item.kind = K_FLUSH;
        end else if (!s_tdata[7]) begin
            q_item.kind = K_ASCII;
        end else if (s_tdata[7:6] == 2'b10) begin
            q_item.kind = K_CONT;
            q_item.bits = {1'b0, s_tdata[5:0]};
        end else if (s_tdata[7:5] == 3'b110) begin
            q_item.kind = K_LEAD2;
            q_item.bits = {2'b00, s_tdata[4:0]};
        end else if (s_tdata[7:4] == 4'b1110) begin
            q_item.kind = K_LEAD3;
            q_item.bits = {3'b000, s_tdata[3:0]};
        end else if (s_tdata[7:3] == 5'b11110) begin
            q_item.kind = K_LEAD4;
            q_item.bits = {4'b0000, s_tdata[2:0]};
        end else begin
            q_item.kind = K_BAD;
        end
    end

endmodule

`default_nettype wire

FILE: design/usd_queue.sv
// usd_queue: two-entry queue between the classifier and the decoder.
// Depends on usd_pkg.
`default_nettype none

module usd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire usd_pkg::usd_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    pop_valid,
    output usd_pkg::usd_item_t      pop_item,
    output logic [1:0]              count
);
    import usd_pkg::*;

    usd_item_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/usd_back.sv
// usd_back: sequence decoder and output register.
// Holds the partial code point; depends on usd_pkg.
`default_nettype none

module usd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire usd_pkg::usd_item_t q_item,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,
    output logic [1:0]              m_tuser
);
    import usd_pkg::*;

    logic [CP_W-1:0]     partial_reg, partial_next;
    logic [1:0]          remain_reg, remain_next;
    logic [LEN_W-1:0]    total_reg, total_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CP_W-1:0]     cp_reg, cp_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                out_free;
    logic                emit;
    logic [CP_W-1:0]     e_cp;
    logic [LEN_W-1:0]    e_len;
    logic [STATUS_W-1:0] e_status;
    logic [CP_W-1:0]     shifted;
    logic [CP_W-1:0]     minimum;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = q_valid && out_free;
    assign shifted  = {partial_reg[CP_W-7:0], q_item.bits[5:0]};

    always_comb begin
        case (total_reg)
            LEN_2:   minimum = MIN_LEN2;
            LEN_3:   minimum = MIN_LEN3;
            default: minimum = MIN_LEN4;
        endcase
    end

    always_comb begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        total_next   = total_reg;
        emit         = 1'b0;
        e_cp         = '0;
        e_len        = '0;
        e_status     = ST_INVALID;
        if (q_pop) begin
            if (q_item.kind == K_FLUSH) begin
                if (remain_reg != 2'd0) begin
                    emit         = 1'b1;
                    e_status     = ST_INCOMPLETE;
                    partial_next = '0;
                    remain_next  = '0;
                    total_next   = '0;
                end
            end else if (remain_reg == 2'd0) begin
                case (q_item.kind)
                    K_ASCII: begin
                        emit     = 1'b1;
                        e_cp     = {{(CP_W-7){1'b0}}, q_item.bits};
                        e_len    = (q_item.bits == 7'd0) ? 3'd0 : 3'd1;
                        e_status = ST_VALID;
                    end
                    K_LEAD2: begin
                        partial_next = {{(CP_W-7){1'b0}}, q_item.bits};
                        total_next   = LEN_2;
                        remain_next  = 2'd1;
                    end
                    K_LEAD3: begin
                        partial_next = {{(CP_W-7){1'b0}}, q_item.bits};
                        total_next   = LEN_3;
                        remain_next  = 2'd2;
                    end
                    K_LEAD4: begin
                        partial_next = {{(CP_W-7){1'b0}}, q_item.bits};
                        total_next   = LEN_4;
                        remain_next  = 2'd3;
                    end
                    default: begin
                        emit = 1'b1;
                    end
                endcase
            end else if (q_item.kind != K_CONT) begin
                emit         = 1'b1;
                partial_next = '0;
                remain_next  = '0;
                total_next   = '0;
            end else if (remain_reg != 2'd1) begin
                partial_next = shifted;
                remain_next  = remain_reg - 2'd1;
            end else begin
                emit         = 1'b1;
                partial_next = '0;
                remain_next  = '0;
                total_next   = '0;
                if (shifted > minimum && shifted <= MAX_CODE) begin
                    e_cp     = shifted;
                    e_len    = total_reg;
                    e_status = ST_VALID;
                end
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        cp_next       = cp_reg;
        len_next      = len_reg;
        status_next   = status_reg;
        if (out_free) begin
            m_tvalid_next = emit;
            cp_next       = e_cp;
            len_next      = e_len;
            status_next   = e_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg  <= '0;
            remain_reg   <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            partial_reg  <= partial_next;
            remain_reg   <= remain_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg     <= cp_next;
        len_reg    <= len_next;
        status_reg <= status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {len_reg, cp_reg};
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

FILE: dv/utf8_stream_decoder_test.sv
// utf8_stream_decoder_test: self-checking bench for the UTF-8 stream decoder.
// Drives byte transfers, predicts each code point and compares it with m_ output.
// Depends on usd_pkg and utf8_stream_decoder.
`timescale 1ns / 100ps

module utf8_stream_decoder_test;

    import usd_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned ITEM_COUNT  = 1350;
    localparam logic [8:0]  FLUSH_ITEM  = 9'h100;

    // opening sequence: bit 8 set means a flush transfer
    localparam logic [8:0] OPENING [28] = '{
        9'h000, 9'h041, 9'h07F,                 // NUL, ASCII, top of ASCII
        9'h080, 9'h0BF, 9'h0FF,                 // stray continuations, bad lead
        9'h0C1, 9'h0BF,                         // overlong two-byte
        9'h0C2, 9'h080,                         // smallest two-byte
        9'h0ED, 9'h0A0, 9'h080,                 // surrogate, accepted
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,         // largest code point
        9'h0F4, 9'h090, 9'h080, 9'h080,         // above the code space
        9'h0C3, 9'h041,                         // lead cut short by ASCII
        9'h0E2, 9'h082, FLUSH_ITEM,             // partial sequence flushed
        FLUSH_ITEM,                             // flush while idle
        9'h0F8                                  // bad lead
    };

    typedef struct packed {
        logic [CP_W-1:0]     cp;
        logic [LEN_W-1:0]    len;
        logic [STATUS_W-1:0] status;
    } utf8_char_t;

    class utf8_char_scoreboard;
        logic [CP_W-1:0]  partial_cp;
        logic [1:0]       cont_left;
        logic [LEN_W-1:0] seq_total;
        utf8_char_t       chars_due[$];
        int               errors;

        function new();
            partial_cp = '0;
            cont_left  = '0;
            seq_total  = '0;
            errors     = 0;
        endfunction

        function void push_char(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len,
                                logic [STATUS_W-1:0] status);
            utf8_char_t c;
            c.cp     = cp;
            c.len    = len;
            c.status = status;
            chars_due.push_back(c);
            partial_cp = '0;
            cont_left  = '0;
            seq_total  = '0;
        endfunction

        function void note_transfer(logic [7:0] data, logic flush);
            logic [CP_W-1:0] floor_cp;
            if (flush) begin
                if (cont_left != 0)
                    push_char('0, '0, ST_INCOMPLETE);
                return;
            end
            if (cont_left == 0) begin
                if (data <= 8'h7F)
                    push_char({13'd0, data}, (data == 8'h00) ? 3'd0 : 3'd1, ST_VALID);
                else if ((data & 8'hE0) == 8'hC0) begin
                    partial_cp = {16'd0, data[4:0]};
                    seq_total  = LEN_2;
                    cont_left  = 2'd1;
                end else if ((data & 8'hF0) == 8'hE0) begin
                    partial_cp = {17'd0, data[3:0]};
                    seq_total  = LEN_3;
                    cont_left  = 2'd2;
                end else if ((data & 8'hF8) == 8'hF0) begin
                    partial_cp = {18'd0, data[2:0]};
                    seq_total  = LEN_4;
                    cont_left  = 2'd3;
                end else
                    push_char('0, '0, ST_INVALID);
                return;
            end
            if ((data & 8'hC0) != 8'h80) begin
                push_char('0, '0, ST_INVALID);
                return;
            end
            partial_cp = {partial_cp[CP_W-7:0], data[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left != 0)
                return;
            floor_cp = (seq_total == LEN_2) ? MIN_LEN2 :
                       (seq_total == LEN_3) ? MIN_LEN3 : MIN_LEN4;
            if (partial_cp <= floor_cp || partial_cp > MAX_CODE)
                push_char('0, '0, ST_INVALID);
            else
                push_char(partial_cp, seq_total, ST_VALID);
        endfunction

        function void check_char(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len,
                                 logic [STATUS_W-1:0] status);
            utf8_char_t want;
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected character, got cp %h len %0d status %0d",
                         $time, cp, len, status);
                errors++;
                return;
            end
            want = chars_due.pop_front();
            if (cp !== want.cp) begin
                $display("%0t: code_point expected %h, got %h", $time, want.cp, cp);
                errors++;
            end
            if (len !== want.len) begin
                $display("%0t: seq_length expected %0d, got %0d", $time, want.len, len);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                errors++;
            end
        endfunction

        function int due();
            return chars_due.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    utf8_char_scoreboard sb = new();

    int unsigned bytes_sent  = 0;
    int unsigned quiet       = 0;
    bit          sender_burst = 1'b0;
    bit          sink_burst   = 1'b0;
    bit          hold_req     = 1'b0;

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] data, input logic flush);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= flush;
        do @(posedge aclk); while (!s_tready);
        sb.note_transfer(data, flush);
        if (!flush)
            bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.due() != 0) @(posedge aclk);
    endtask

    // len 1..4; cp is cut to the payload bits that the lead and continuations carry
    task automatic send_sequence(input int unsigned len, input logic [CP_W-1:0] cp,
                                 input int unsigned sent_len);
        logic [7:0] seq [4];
        for (int k = 1; k < len; k++)
            seq[k] = {2'b10, cp[6*(len-1-k) +: 6]};
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: seq[0] = {3'b110, cp[10:6]};
            3: seq[0] = {4'b1110, cp[15:12]};
            default: seq[0] = {5'b11110, cp[20:18]};
        endcase
        for (int k = 0; k < sent_len; k++)
            send_item(seq[k], 1'b0);
    endtask

    task automatic send_random_char();
        int unsigned pick;
        int unsigned len;
        logic [CP_W-1:0] cp;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        if (pick < 60) begin
            case (len)
                1: cp = CP_W'($urandom_range(0, 'h7F));
                2: cp = CP_W'($urandom_range('h80, 'h7FF));
                3: cp = CP_W'($urandom_range('h800, 'hFFFF));
                default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
            endcase
            send_sequence(len, cp, len);
        end else if (pick < 80) begin
            cp = CP_W'($urandom_range(0, 'h1FFFFF));
            send_sequence(len, cp, len);
        end else if (pick < 88) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 95) begin
            len = $urandom_range(2, 4);
            cp  = CP_W'($urandom_range(0, 'h1FFFFF));
            send_sequence(len, cp, $urandom_range(1, len - 1));
            if ($urandom_range(0, 1))
                send_item(8'($urandom_range(0, 255)), 1'b1);
            else
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = sink_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_char(m_tdata[20:0], m_tdata[23:21], m_tuser);
            if ($urandom_range(0, 39) == 0)
                sink_burst = !sink_burst;
        end
    end

    initial begin
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (OPENING[i])
            send_item(OPENING[i][7:0], OPENING[i][8]);

        while (bytes_sent < ITEM_COUNT) begin
            if (!hold_done && bytes_sent >= 400) begin
                hold_done    = 1'b1;
                hold_req     = 1'b1;
                sender_burst = 1'b1;
                repeat (40) send_item(8'($urandom_range(1, 'h7F)), 1'b0);
                sender_burst = 1'b0;
            end
            if (!drain_done && bytes_sent >= 800) begin
                drain_done = 1'b1;
                wait_drained();
            end
            send_random_char();
            if ($urandom_range(0, 39) == 0)
                sender_burst = !sender_burst;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.due() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
design/usd_pkg.sv
design/usd_front.sv
design/usd_queue.sv
design/usd_back.sv
design/utf8_stream_decoder.sv
dv/utf8_stream_decoder_test.sv
